@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of the segment access checker.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low reset gating (disable iff), fixed message.
`define SAC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sac assertion failed");

// Same, with a caller-supplied message string.
`define SAC_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

`endif

@@ hdl/sac_pkg.sv @@
// Types and constants of the segment access checker.
// Used by the region cells, the top level and the port checker.
`default_nettype none

package sac_pkg;

    localparam int ADDR_W      = 16;
    localparam int BASE_W      = 32;
    localparam int LIMIT_W     = 16;
    localparam int SLOT_W      = 4;
    localparam int PERM_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 2;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 8;

    localparam logic [ADDR_W-1:0] VECTOR_AREA_END = 16'h0400;

    // permission bit positions
    localparam int PERM_READ_BIT  = 0;
    localparam int PERM_WRITE_BIT = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROT_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIV_LEVEL  = 2'd1;

    // input kinds carried in s_tuser
    localparam logic FUNC_CHECK = 1'b0;
    localparam logic FUNC_LOAD  = 1'b1;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_VECTOR    = 2'd1,
        FAULT_PERM      = 2'd2,
        FAULT_NO_REGION = 2'd3
    } sac_fault_t;

    // one item moving down the row of cells, with its decision so far
    typedef struct packed {
        logic                is_load;
        logic [ADDR_W-1:0]   addr;
        logic                is_write;
        logic [SLOT_W-1:0]   slot;
        logic [BASE_W-1:0]   base;
        logic [LIMIT_W-1:0]  limit;
        logic [PERM_W-1:0]   perm;
        logic                decided;
        logic                allowed;
        sac_fault_t          fault;
        logic [SLOT_W-1:0]   matched;
        logic                hit;
    } sac_tok_t;

endpackage

`default_nettype wire

@@ hdl/segment_access_checker.sv @@
// Top level of the segment access checker: entry decode, row of region cells, result register.
// Depends on sac_pkg and sac_cell.
//
//  channel   direction  beat contents
//  s_        in         tuser: func; tdata: address, write flag, slot, base, limit, perms
//  m_        out        tdata: allowed, fault_kind, matched_entry, region_matched
//  cfg_      in         cfg_index, cfg_data (protection enable, privilege level)
//
// An item walks one cell per cycle while the row advances; a check passes every cell and then
// the result register, and one item is taken per cycle unless the m_ output stalls.
// Loads travel the same row, so every check sees exactly the loads accepted before it.
// aresetn clears all entry valid bits, the configuration and the pipeline.
// A stalled m_ beat freezes the whole row and holds s_tready low.
`default_nettype none

module segment_access_checker #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [15:0] access_address, [16] access_is_write, [20:17] entry_index,
    // [52:21] entry_base, [68:53] entry_limit, [69] entry_read_ok,
    // [70] entry_write_ok, [71] zero
    input  wire logic [sac_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic                               s_tuser,   // [0] func
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [0] allowed, [2:1] fault_kind, [6:3] matched_entry, [7] region_matched
    output logic [sac_pkg::M_TDATA_W-1:0]           m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [sac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sac_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sac_pkg::*;

    logic       prot_en_reg;
    logic [1:0] priv_reg;

    logic       advance;
    logic       m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    sac_tok_t   head_tok;
    sac_tok_t   last_tok;

    logic       tok_vld [TABLE_ENTRIES+1];
    sac_tok_t   tok     [TABLE_ENTRIES+1];

    assign advance   = !m_tvalid_reg || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prot_en_reg <= 1'b0;
            priv_reg    <= 2'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_PROT_ENABLE: prot_en_reg <= cfg_data[0];
                CFG_PRIV_LEVEL:  priv_reg    <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // unpack the beat and settle the cases that need no table lookup
    always_comb begin
        head_tok          = '0;
        head_tok.is_load  = (s_tuser == FUNC_LOAD);
        head_tok.addr     = s_tdata[15:0];
        head_tok.is_write = s_tdata[16];
        head_tok.slot     = s_tdata[20:17];
        head_tok.base     = s_tdata[52:21];
        head_tok.limit    = s_tdata[68:53];
        head_tok.perm     = {s_tdata[70], s_tdata[69]};
        head_tok.fault    = FAULT_NONE;
        if (!prot_en_reg || priv_reg == 2'd0) begin
            head_tok.decided = 1'b1;
            head_tok.allowed = 1'b1;
        end else if (s_tdata[15:0] < VECTOR_AREA_END) begin
            head_tok.decided = 1'b1;
            head_tok.fault   = FAULT_VECTOR;
        end
    end

    assign tok_vld[0] = s_tvalid;
    assign tok[0]     = head_tok;

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        sac_cell #(
            .CELL_INDEX(i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .in_vld  (tok_vld[i]),
            .in_tok  (tok[i]),
            .out_vld (tok_vld[i+1]),
            .out_tok (tok[i+1])
        );
    end

    assign last_tok = tok[TABLE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= tok_vld[TABLE_ENTRIES] && !last_tok.is_load;
        end
    end

    // register the result; an undecided check at the end of the row had no region covering it
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (last_tok.decided) begin
                m_tdata_reg <= {last_tok.hit, last_tok.matched, last_tok.fault,
                                last_tok.allowed};
            end else begin
                m_tdata_reg <= {1'b0, SLOT_W'(0), FAULT_NO_REGION, 1'b0};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ hdl/sac_cell.sv @@
// One region cell: holds a single table entry and processes the item passing by.
// Depends on sac_pkg.
`default_nettype none

module sac_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic              in_vld,
    input  wire sac_pkg::sac_tok_t in_tok,
    output logic                   out_vld,
    output sac_pkg::sac_tok_t      out_tok
);
    import sac_pkg::*;

    localparam logic [SLOT_W-1:0] MY_SLOT  = SLOT_W'(CELL_INDEX);
    localparam bit                LOADABLE = (CELL_INDEX < (1 << SLOT_W));

    logic              entry_vld_reg;
    logic [BASE_W-1:0] entry_base_reg;
    logic [BASE_W-1:0] top_reg;
    logic [PERM_W-1:0] perm_reg;

    logic              out_vld_reg;
    sac_tok_t          out_tok_reg;
    sac_tok_t          tok_next;

    logic              load_here;
    logic              hit;
    logic              perm_ok;
    logic [BASE_W-1:0] addr_ext;

    assign addr_ext  = BASE_W'(in_tok.addr);
    assign load_here = LOADABLE && in_vld && in_tok.is_load && (in_tok.slot == MY_SLOT);
    assign hit       = entry_vld_reg && in_vld && !in_tok.is_load && !in_tok.decided &&
                       (addr_ext >= entry_base_reg) && (addr_ext <= top_reg);
    assign perm_ok   = in_tok.is_write ? perm_reg[PERM_WRITE_BIT] : perm_reg[PERM_READ_BIT];

    always_comb begin
        tok_next = in_tok;
        if (hit) begin
            tok_next.decided = 1'b1;
            tok_next.hit     = 1'b1;
            tok_next.matched = MY_SLOT;
            tok_next.allowed = perm_ok;
            tok_next.fault   = perm_ok ? FAULT_NONE : FAULT_PERM;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_vld_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= in_vld;
            if (load_here) begin
                entry_vld_reg <= 1'b1;
            end
        end
    end

    // entry payload and item payload carry no reset
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_tok_reg <= tok_next;
            if (load_here) begin
                entry_base_reg <= in_tok.base;
                top_reg        <= in_tok.base + BASE_W'(in_tok.limit);
                perm_reg       <= in_tok.perm;
            end
        end
    end

    assign out_vld = out_vld_reg;
    assign out_tok = out_tok_reg;

endmodule

`default_nettype wire

@@ hdl/sac_checker.sv @@
// Port-level checker for the segment access checker, bound to the top level.
// Depends on sac_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sac_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [sac_pkg::M_TDATA_W-1:0]  m_tdata
);
    import sac_pkg::*;

    logic       allowed;
    logic [1:0] fault;
    logic [3:0] matched;
    logic       region_hit;

    assign allowed    = m_tdata[0];
    assign fault      = m_tdata[2:1];
    assign matched    = m_tdata[6:3];
    assign region_hit = m_tdata[7];

    `SAC_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `SAC_ASSERT_MSG(a_allow_no_fault, aclk, aresetn,
        m_tvalid |-> (allowed == (fault == FAULT_NONE)), "allowed disagrees with fault_kind")
    `SAC_ASSERT_MSG(a_idx_zero_on_miss, aclk, aresetn,
        m_tvalid && !region_hit |-> (matched == 4'd0), "matched_entry set without a region")
    `SAC_ASSERT_MSG(a_hit_kind, aclk, aresetn,
        m_tvalid |-> (region_hit == (fault == FAULT_PERM ||
                                     (fault == FAULT_NONE && region_hit))),
        "region_matched disagrees with fault_kind")

endmodule

bind segment_access_checker sac_checker u_sac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
